>>> rtl/core/wkp_pkg.sv
// wks record port bitmap parser: shared types and constants
// no dependencies; imported by every module of the block

package wkp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned OFFS_W   = 16;
    localparam int unsigned M_DATA_W = 64;

    // record header: four address bytes then the protocol byte
    localparam logic [OFFS_W-1:0] HDR_LEN   = 16'd5;
    localparam logic [OFFS_W-1:0] ADDR_LEN  = 16'd4;
    localparam logic [OFFS_W-1:0] OFFS_MAX  = 16'hFFFF;
    localparam logic [PORT_W-1:0] LIMIT_RST = 16'd1023;

    localparam logic KIND_PORT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_SHORT = 1'b1;

    // one decoded input byte, waiting to be turned into result transfers
    typedef struct packed {
        logic [BYTE_W-1:0] mask;     // accepted port bits, index 0 = byte msb
        logic [PORT_W-1:0] base;     // port number of index 0
        logic              summary;  // record end summary follows the ports
        logic [ADDR_W-1:0] host;
        logic [BYTE_W-1:0] proto;
        logic              status;
    } job_t;

endpackage

>>> rtl/core/wkp_front.sv
// wks record port bitmap parser: record state and per-byte bitmap decode
// depends on wkp_pkg

module wkp_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [wkp_pkg::PORT_W-1:0] cfg_wr_data,
    input  logic                       in_fire,
    input  logic [wkp_pkg::BYTE_W-1:0] in_byte,
    input  logic                       in_last,
    output wkp_pkg::job_t              job
);
    import wkp_pkg::*;

    logic [OFFS_W-1:0] offset_reg, offset_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0] proto_reg, proto_next;
    logic              stopped_reg, stopped_next;
    logic [PORT_W-1:0] limit_reg;

    logic [OFFS_W+2:0] base_w;
    logic [BYTE_W-1:0] bit_set, over, keep;
    logic              in_scan, stop_hit, is_short;

    // bitmap byte b covers ports 8*b .. 8*b+7, msb first
    assign base_w  = {offset_reg - HDR_LEN, 3'b000};
    assign in_scan = (offset_reg >= HDR_LEN) && !stopped_reg;

    always_comb begin
        for (int i = 0; i < BYTE_W; i++) begin
            bit_set[i] = in_byte[BYTE_W-1-i];
            over[i]    = ({1'b0, base_w} + (OFFS_W+4)'(i)) > (OFFS_W+4)'(limit_reg);
        end
    end

    // ports rise with the index, so every bit past the first over-limit one is over too
    assign keep     = in_scan ? (bit_set & ~over) : '0;
    assign stop_hit = in_scan && ((bit_set & over) != '0);
    assign is_short = (offset_reg < ADDR_LEN);

    always_comb begin
        addr_next    = addr_reg;
        proto_next   = proto_reg;
        stopped_next = stopped_reg | stop_hit;
        offset_next  = (offset_reg == OFFS_MAX) ? offset_reg : offset_reg + 16'd1;
        if (offset_reg < ADDR_LEN) begin
            addr_next = {addr_reg[ADDR_W-BYTE_W-1:0], in_byte};
        end else if (offset_reg == ADDR_LEN) begin
            proto_next = in_byte;
        end
    end

    always_comb begin
        job.mask    = keep;
        job.base    = base_w[PORT_W-1:0];
        job.summary = in_last;
        job.host    = is_short ? '0 : addr_next;
        job.proto   = is_short ? '0 : proto_next;
        job.status  = is_short ? STATUS_SHORT : STATUS_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg  <= '0;
            addr_reg    <= '0;
            proto_reg   <= '0;
            stopped_reg <= 1'b0;
            limit_reg   <= LIMIT_RST;
        end else begin
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (in_fire) begin
                if (in_last) begin
                    offset_reg  <= '0;
                    addr_reg    <= '0;
                    proto_reg   <= '0;
                    stopped_reg <= 1'b0;
                end else begin
                    offset_reg  <= offset_next;
                    addr_reg    <= addr_next;
                    proto_reg   <= proto_next;
                    stopped_reg <= stopped_next;
                end
            end
        end
    end

endmodule

>>> rtl/core/wkp_emit.sv
// wks record port bitmap parser: job register and result sequencer
// depends on wkp_pkg

module wkp_emit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_fire,
    input  wkp_pkg::job_t                job,
    output logic                         job_take,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [wkp_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser,
    output logic                         m_tlast
);
    import wkp_pkg::*;

    job_t                job_reg, job_next;
    logic                busy_reg;
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg, out_data_next;
    logic                out_kind_reg, out_kind_next;
    logic                out_last_reg, out_last_next;

    logic                out_free, emit, done;
    logic [2:0]          idx;
    logic [BYTE_W-1:0]   rest;

    assign out_free = !out_valid_reg || m_tready;

    // lowest index first, i.e. msb of the bitmap byte first
    always_comb begin
        idx = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            if (job_reg.mask[i]) begin
                idx = 3'(i);
            end
        end
    end

    assign rest = job_reg.mask & ~(8'b1 << idx);

    always_comb begin
        emit          = 1'b0;
        done          = 1'b0;
        job_next      = job_reg;
        out_data_next = out_data_reg;
        out_kind_next = out_kind_reg;
        out_last_next = out_last_reg;
        if (busy_reg) begin
            if (job_reg.mask != '0) begin
                if (out_free) begin
                    emit          = 1'b1;
                    job_next.mask = rest;
                    done          = (rest == '0) && !job_reg.summary;
                    out_kind_next = KIND_PORT;
                    out_last_next = done;
                    out_data_next = M_DATA_W'(job_reg.base + PORT_W'(idx));
                end
            end else if (job_reg.summary) begin
                if (out_free) begin
                    emit          = 1'b1;
                    done          = 1'b1;
                    out_kind_next = KIND_SUMMARY;
                    out_last_next = 1'b1;
                    out_data_next = {7'b0, job_reg.status, job_reg.proto, job_reg.host,
                                     {PORT_W{1'b0}}};
                end
            end else begin
                done = 1'b1;    // byte with nothing to report
            end
        end
    end

    assign job_take = !busy_reg || done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                busy_reg <= 1'b1;
            end else if (done) begin
                busy_reg <= 1'b0;
            end
            out_valid_reg <= emit || (out_valid_reg && !m_tready);
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= in_fire ? job : job_next;
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/core/wks_record_port_bitmap_parser.sv
// wks record port bitmap parser: top level
// depends on wkp_pkg, wkp_front and wkp_emit
//
// usage
//  - slave channel: one record data byte per transfer in s_tdata, s_tlast on the
//    final byte of the record; bytes 0-3 are the big-endian ipv4 address, byte 4
//    the ip protocol, every later byte a slice of the port bitmap, msb first
//  - master channel: one result per transfer; m_tuser = 0 for a port found,
//    1 for the record end summary; m_tlast marks the last result of an input byte
//  - cfg_wr_en / cfg_wr_data write the port limit (reset 1023); the first set
//    bitmap bit above it ends scanning for the rest of the record
//  - result path: the transfer edge loads a byte into the job register, and its
//    first result then moves into the output register, which drives m_tvalid
//  - throughput: one result per cycle from the output register while m_tready is
//    high; a byte (0 to 9 results) leaves the job register once its last result,
//    if any, is taken, so header and sparse bitmap bytes stream at one per cycle
//  - a stall on m_tready holds the output register; the job register and then
//    s_tready back up behind it, nothing is dropped
//  - reset (aresetn low, synchronous) empties both registers, clears the record
//    state and restores the port limit; no clearing pass is needed

module wks_record_port_bitmap_parser (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [wkp_pkg::PORT_W-1:0]   cfg_wr_data,   // port_limit

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wkp_pkg::BYTE_W-1:0]   s_tdata,       // [7:0] data_byte
    input  logic                         s_tlast,       // last_byte

    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [15:0] port_number, [47:16] host_address, [55:48] ip_protocol,
    // [56] status, [63:57] zero
    output logic [wkp_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tuser,       // kind
    output logic                         m_tlast        // final_res
);
    import wkp_pkg::*;

    job_t job;
    logic in_fire;
    logic job_take;

    // a new byte enters whenever the job register empties this cycle
    assign s_tready = job_take;
    assign in_fire  = s_tvalid && job_take;

    wkp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .job         (job)
    );

    wkp_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .job      (job),
        .job_take (job_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> bench/tb_wks_record_port_bitmap_parser.sv
// self-checking bench for the wks record port bitmap parser
// streams record bytes with random gaps and stalls, predicts every result in-line
// depends on wkp_pkg and wks_record_port_bitmap_parser

module tb_wks_record_port_bitmap_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import wkp_pkg::*;

    // cycles with no transfer on either channel before the run is called hung
    localparam int WATCHDOG_LIMIT = 2000;
    // cycles allowed for a byte with no result to leave the job register
    localparam int SETTLE_CYCLES  = 16;
    // idle chance per side, percent
    localparam int IDLE_PCT       = 12;
    // number of mismatch lines printed before going quiet
    localparam int PRINT_CAP      = 40;

    // one record byte waiting to be sent
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              drain;   // hold off until all expected results are in
    } rec_byte_t;

    // one expected result transfer
    typedef struct {
        logic              kind;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] host;
        logic [BYTE_W-1:0] proto;
        logic              status;
        logic              last_of_byte;
    } wks_res_t;

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PORT_W-1:0]   cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata     = '0;
    logic                s_tlast     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    wks_record_port_bitmap_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),      // [7:0] data_byte
        .s_tlast     (s_tlast),      // last_byte
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),      // [15:0] port, [47:16] host, [55:48] proto, [56] status
        .m_tuser     (m_tuser),      // kind
        .m_tlast     (m_tlast)       // final_res
    );

    // stimulus and expectation stores
    rec_byte_t pend_q[$];
    wks_res_t  port_res_q[$];

    // predictor state, mirrors the record decoder
    logic [PORT_W-1:0] port_limit = LIMIT_RST;
    logic [OFFS_W-1:0] rec_offset = '0;
    logic [ADDR_W-1:0] rec_addr   = '0;
    logic [BYTE_W-1:0] rec_proto  = '0;
    logic              rec_stopped = 1'b0;

    // bookkeeping
    bit calm  = 1'b0;     // no idling on either side while set
    bit taken = 1'b0;     // the byte on the bus went across at the last edge
    int n_pushed, n_in, n_out, n_errors, n_port_hits, n_summaries, n_short, n_stops, n_cfg;
    int quiet_cycles;

    // free-running clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor: one accepted byte in, its result transfers appended
    // ------------------------------------------------------------------
    task automatic predict_byte(input logic [BYTE_W-1:0] b, input logic last);
        wks_res_t    res[10];
        int          n;
        int          i;
        int unsigned base;
        int unsigned port;
        n = 0;
        if (rec_offset < ADDR_LEN) begin
            // big-endian address shift
            rec_addr = {rec_addr[ADDR_W-9:0], b};
        end else if (rec_offset == ADDR_LEN) begin
            rec_proto = b;
        end else if (!rec_stopped) begin
            // ports are kept wide so anything past 65535 exceeds every limit
            base = (32'(rec_offset) - 32'(HDR_LEN)) * 8;
            for (i = 0; i < 8; i++) begin
                if (b[7-i] && !rec_stopped) begin
                    port = base + i;
                    if (port > 32'(port_limit)) begin
                        rec_stopped = 1'b1;
                        n_stops++;
                    end else begin
                        res[n] = '{KIND_PORT, port[PORT_W-1:0], '0, '0, STATUS_OK, 1'b0};
                        n++;
                    end
                end
            end
        end
        if (rec_offset != OFFS_MAX) rec_offset++;
        if (last) begin
            // short record reports no address or protocol
            if (rec_offset < HDR_LEN)
                res[n] = '{KIND_SUMMARY, '0, '0, '0, STATUS_SHORT, 1'b0};
            else
                res[n] = '{KIND_SUMMARY, '0, rec_addr, rec_proto, STATUS_OK, 1'b0};
            n++;
            rec_offset  = '0;
            rec_addr    = '0;
            rec_proto   = '0;
            rec_stopped = 1'b0;
        end
        if (n > 0) res[n-1].last_of_byte = 1'b1;
        for (i = 0; i < n; i++) port_res_q.push_back(res[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("mismatch on %0s at result %0d: got %0h want %0h", what, n_out, got, want);
    endtask

    task automatic check_result();
        wks_res_t want;
        if (port_res_q.size() == 0) begin
            report_mismatch("unexpected result", m_tdata[31:0], '0);
        end else begin
            want = port_res_q.pop_front();
            if (m_tuser !== want.kind)             report_mismatch("kind", m_tuser, want.kind);
            if (m_tdata[15:0] !== want.port)       report_mismatch("port", m_tdata[15:0], want.port);
            if (m_tdata[47:16] !== want.host)      report_mismatch("host", m_tdata[47:16], want.host);
            if (m_tdata[55:48] !== want.proto)     report_mismatch("proto", m_tdata[55:48], want.proto);
            if (m_tdata[56] !== want.status)       report_mismatch("status", m_tdata[56], want.status);
            if (m_tdata[63:57] !== 7'd0)           report_mismatch("padding", m_tdata[63:57], '0);
            if (m_tlast !== want.last_of_byte)     report_mismatch("tlast", m_tlast, want.last_of_byte);
            if (want.kind == KIND_SUMMARY) begin
                n_summaries++;
                if (want.status == STATUS_SHORT) n_short++;
            end else begin
                n_port_hits++;
            end
        end
        n_out++;
    endtask

    // ------------------------------------------------------------------
    // monitor: samples both channels at the rising edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_byte(s_tdata, s_tlast);
                taken = 1'b1;
                n_in++;
            end
            if (m_tvalid && m_tready) check_result();
            // hang detection counts edges with no transfer at all
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // driver: changes inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : drv
        rec_byte_t nxt;
        if (aresetn) begin
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            // bus is free when nothing is offered or the offer just went across
            if (!s_tvalid || taken) begin
                taken = 1'b0;
                if (pend_q.size() > 0 && !(pend_q[0].drain && port_res_q.size() > 0) &&
                    (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last,
                             input logic drain = 1'b0);
        pend_q.push_back('{b, last, drain});
        n_pushed++;
    endtask

    // four address bytes msb first, then the protocol byte
    task automatic push_header(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] proto,
                               input logic ends);
        push_byte(addr[31:24], 1'b0);
        push_byte(addr[23:16], 1'b0);
        push_byte(addr[15:8], 1'b0);
        push_byte(addr[7:0], 1'b0);
        push_byte(proto, ends);
    endtask

    // wait for an empty pipe: everything sent, accepted and answered
    task automatic wait_idle();
        do @(negedge aclk);
        while (pend_q.size() != 0 || n_in != n_pushed || port_res_q.size() != 0 || s_tvalid);
    endtask

    // register write only between phases, after bytes with no result have drained
    task automatic set_port_limit(input logic [PORT_W-1:0] v);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        port_limit = v;
        n_cfg++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [BYTE_W-1:0] bitmap_byte();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h00;
            3:       return 8'hFF;
            4, 5:    return 8'h01 << $urandom_range(0, 7);
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly well formed records with random content, some cut short
    task automatic run_random_phase(input int budget);
        int sent;
        int len;
        int i;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(0, 99) < 15)
                len = $urandom_range(1, 4);
            else
                len = 5 + $urandom_range(0, 10);
            for (i = 0; i < len; i++) begin
                b = (i < 5) ? 8'($urandom_range(0, 255)) : bitmap_byte();
                push_byte(b, i == len - 1, $urandom_range(0, 99) < 3);
            end
            sent += len;
        end
    endtask

    // one longer record with full bitmap bytes well past the first ports
    task automatic push_long_record();
        int off;
        push_header(32'h5AA5_C33C, 8'h11, 1'b0);
        for (off = 5; off < 20; off++) begin
            if (off == 12 || off == 18)
                push_byte(8'hFF, 1'b0);          // eight ports each
            else
                push_byte(8'($urandom_range(0, 255)), off == 19);
        end
    endtask

    // hang guard
    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset limit: short records, bare header, dense bitmap bytes
        push_byte(8'h5A, 1'b1);                  // single-byte record
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);                  // four bytes, still short
        push_header(32'h0000_0000, 8'h00, 1'b1); // header only
        push_header(32'hC0A8_0102, 8'h06, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b1);            // eight ports, sent after a full drain
        push_byte(8'h81, 1'b0);
        push_byte(8'hFF, 1'b1);                  // eight ports plus the summary

        // lowest limit: port 0 passes, port 1 ends the scan
        set_port_limit(16'h0000);
        push_header(32'hFFFF_FFFF, 8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);

        // limit raised in the middle of a record
        push_header(32'h0102_0304, 8'h11, 1'b0);
        push_byte(8'h00, 1'b0);
        set_port_limit(16'd10);
        push_byte(8'hFF, 1'b1);                  // ports 8, 9, 10 then stop

        // highest limit with a longer record of mixed bitmap bytes
        set_port_limit(16'hFFFF);
        push_long_record();

        // random phases over several limits, one with no idling at all
        set_port_limit(16'($urandom_range(0, 40)));
        run_random_phase(40);
        set_port_limit(16'hFFFF);
        wait_idle();
        calm = 1'b1;
        run_random_phase(40);
        wait_idle();
        calm = 1'b0;
        set_port_limit(16'($urandom_range(0, 65535)));
        run_random_phase(40);
        set_port_limit(LIMIT_RST);
        run_random_phase(40);
        set_port_limit(16'($urandom_range(8, 100)));
        run_random_phase(40);

        // let the pipe run dry, then give stray results a chance to show
        wait_idle();
        repeat (SETTLE_CYCLES + 4) @(posedge aclk);
        if (port_res_q.size() != 0) report_mismatch("missing results", port_res_q.size(), '0);

        $display("covered %0d bytes, %0d limit writes, %0d scan stops", n_in, n_cfg, n_stops);
        $display("checked %0d port hits and %0d summaries (%0d short records)",
                 n_port_hits, n_summaries, n_short);
        if (n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> wks_record_port_bitmap_parser.f
rtl/core/wkp_pkg.sv
rtl/core/wkp_front.sv
rtl/core/wkp_emit.sv
rtl/core/wks_record_port_bitmap_parser.sv
bench/tb_wks_record_port_bitmap_parser.sv
